### sv/assert_macros.svh
// Assertion helpers for the index-to-coordinate block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define HIXY_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define HIXY_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/hixy_pkg.sv
package hixy_pkg;

   localparam int OrderW = 5;
   localparam int IndexW = 62;
   localparam int CoordW = 31;
   localparam int ShiftW = 7;

   localparam logic [1:0] DIG_TRANSPOSE = 2'd0;
   localparam logic [1:0] DIG_OFFSET_Y  = 2'd1;
   localparam logic [1:0] DIG_OFFSET_XY = 2'd2;
   localparam logic [1:0] DIG_REFLECT   = 2'd3;

   typedef struct packed {
      logic [OrderW-1:0] order;
      logic [IndexW-1:0] index;
   } req_type;

   typedef struct packed {
      logic [CoordW-1:0] coord_x;
      logic [CoordW-1:0] coord_y;
      logic              index_too_big;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic check;
      logic step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic too_big;
      logic order_zero;
      logic last_step;
   } sts_type;

endpackage

### sv/hixy_dp.sv
module hixy_dp import hixy_pkg::*; #(
   parameter int MAX_ORDER = 31
) (
   input  logic    clock,
   input  req_type req_word,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_word
);

   localparam int W  = MAX_ORDER;
   localparam int CW = $clog2(MAX_ORDER + 1);
   localparam logic [OrderW-1:0] MaxOrd = OrderW'(MAX_ORDER);

   logic [IndexW-1:0] index_ff, index_in;
   logic [W-1:0]      x_ff, x_in;
   logic [W-1:0]      y_ff, y_in;
   logic [W-1:0]      half_ff, half_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              big_ff, big_in;
   rsp_type           out_ff, out_in;

   logic [OrderW-1:0] sat_order;
   logic [ShiftW-1:0] lv2;
   logic [IndexW-1:0] hi_mask;
   logic              too_big;

   assign sat_order = (req_word.order > MaxOrd) ? MaxOrd : req_word.order;
   assign lv2 = ShiftW'(cnt_ff) << 1;

   always_comb begin
      for (int i = 0; i < IndexW; i++) begin
         hi_mask[i] = (ShiftW'(i) >= lv2);
      end
   end

   assign too_big = |(index_ff & hi_mask);

   always_comb begin
      index_in = index_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      half_in  = half_ff;
      cnt_in   = cnt_ff;
      big_in   = big_ff;
      out_in   = out_ff;
      if (cmd.load) begin
         index_in = req_word.index;
         x_in     = '0;
         y_in     = '0;
         half_in  = W'(1);
         cnt_in   = CW'(sat_order);
         big_in   = 1'b0;
      end
      if (cmd.check) begin
         big_in = too_big;
      end
      if (cmd.step) begin
         unique case (index_ff[1:0])
            DIG_TRANSPOSE: begin
               x_in = y_ff;
               y_in = x_ff;
            end
            DIG_OFFSET_Y: begin
               y_in = y_ff + half_ff;
            end
            DIG_OFFSET_XY: begin
               x_in = x_ff + half_ff;
               y_in = y_ff + half_ff;
            end
            DIG_REFLECT: begin
               x_in = (half_ff << 1) - y_ff - W'(1);
               y_in = half_ff - x_ff - W'(1);
            end
            default: begin
               x_in = x_ff;
            end
         endcase
         index_in = index_ff >> 2;
         half_in  = half_ff << 1;
         cnt_in   = cnt_ff - CW'(1);
      end
      if (cmd.load_out) begin
         out_in.coord_x       = CoordW'(x_ff);
         out_in.coord_y       = CoordW'(y_ff);
         out_in.index_too_big = big_ff;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      half_ff  <= half_in;
      cnt_ff   <= cnt_in;
      big_ff   <= big_in;
      out_ff   <= out_in;
   end

   assign sts.too_big    = too_big;
   assign sts.order_zero = (cnt_ff == '0);
   assign sts.last_step  = (cnt_ff == CW'(1));
   assign rsp_word       = out_ff;

endmodule

### sv/hixy_ctrl.sv
module hixy_ctrl import hixy_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_STEP   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.too_big || sts.order_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (sts.last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/hilbert_index_to_xy.sv
// An accepted request is loaded, checked in ST_CHECK, then walked through ST_STEP and
// registered in ST_FINISH once the output slot is free, which raises rsp_valid. Order
// zero or an out-of-range index skips ST_STEP. A new request is taken only in idle; the
// level walk advances one curve level per cycle through a single transform unit.
// Reset: synchronous, active high; clears the controller and the output valid flag.
module hilbert_index_to_xy import hixy_pkg::*; #(
   parameter int MAX_ORDER = 31
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   cmd_type cmd;
   sts_type sts;

   hixy_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hixy_dp #(
      .MAX_ORDER (MAX_ORDER)
   ) u_dp (
      .clock    (clock),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_word)
   );

endmodule

### sv/hixy_checker.sv
`include "assert_macros.svh"

module hixy_assertions import hixy_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_word
);

   `HIXY_ASSERT_ALWAYS(a_reset_clears_valid, reset |=> !rsp_valid, "rsp_valid after reset")

   `HIXY_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "ready after accept")

   `HIXY_ASSERT(a_big_zero_coords, (rsp_valid && rsp_word.index_too_big) |-> (rsp_word.coord_x == '0 && rsp_word.coord_y == '0), "nonzero coordinates on out-of-range index")

   `HIXY_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)), "stalled response changed")

endmodule

bind hilbert_index_to_xy hixy_assertions u_hixy_assertions (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
